[hdl/mbp_pkg.sv]
`default_nettype none

package mbp_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_ZERO  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    // Operation kind carried from front to back
    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_FLUSH  = 1'b1
    } op_t;

    localparam int BYTE_BITS = 8;
    localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

    // Result word: byte, valid bit count, last flag
    localparam int RES_W = BYTE_BITS + 4 + 1;

endpackage

`default_nettype wire

[hdl/msb_first_bit_packer.sv]
`default_nettype none

// MSB-first bit packer. Each input word appends the low bit_count bits of
// data_bits (highest first), appends bit_count zero bits, or flushes the
// partial byte; counts above MAX_CHUNK_BITS are clamped and an unused
// command is dropped. Completed bytes come out in order with the earliest
// bit in bit 7, valid_bits = 8 except on a flushed partial byte (which is
// zero padded), and last marks the final byte caused by an input word.
// Up to 7 bits wait between words. Both sides are queue style: push/full
// on the input, empty/pop on the result side, each backed by a two-entry
// queue so either side may stall on its own. An input word holds the
// packing engine until it has emitted the N bytes the word completes (at
// most 8), one byte per cycle from its shift register while the result
// queue is not full; words completing no byte pass at one per cycle too.
module msb_first_bit_packer
    import mbp_pkg::*;
#(
    parameter int MAX_CHUNK_BITS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  cmd,
    input  wire logic [63:0] data_bits,
    input  wire logic [6:0]  bit_count,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       byte_out,
    output logic [3:0]       valid_bits,
    output logic             last
);

    localparam int W     = MAX_CHUNK_BITS;
    localparam int CNT_W = $clog2(W + 1);
    localparam int E_W   = 1 + CNT_W + W;

    // front -> queue
    logic             f_keep;
    op_t              f_op;
    logic [CNT_W-1:0] f_cnt;
    logic [W-1:0]     f_data;
    logic             q_full;

    // queue -> back
    logic [E_W-1:0]   q_rd;
    logic             q_empty;
    logic             q_pop;

    // back -> result queue
    logic             o_full;
    logic             o_push;
    logic [RES_W-1:0] o_word;
    logic [RES_W-1:0] r_word;

    assign full = q_full;

    mbp_front #(
        .W     (W),
        .CNT_W (CNT_W)
    ) u_front (
        .cmd       (cmd),
        .data_bits (data_bits[W-1:0]),
        .bit_count (bit_count),
        .keep      (f_keep),
        .op        (f_op),
        .cnt       (f_cnt),
        .data_left (f_data)
    );

    // Work queue between classifier and packing engine
    mbp_fifo #(
        .WIDTH (E_W)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && f_keep),
        .wr_data ({f_op, f_cnt, f_data}),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    mbp_back #(
        .W     (W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .e_op    (op_t'(q_rd[E_W-1])),
        .e_cnt   (q_rd[W +: CNT_W]),
        .e_data  (q_rd[W-1:0]),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_word  (o_word)
    );

    // Result queue decouples byte output from the engine
    mbp_fifo #(
        .WIDTH (RES_W)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (o_push),
        .wr_data (o_word),
        .full    (o_full),
        .rd_en   (pop),
        .rd_data (r_word),
        .empty   (empty)
    );

    assign byte_out   = r_word[RES_W-1 -: BYTE_BITS];
    assign valid_bits = r_word[4:1];
    assign last       = r_word[0];

endmodule

`default_nettype wire

[hdl/mbp_fifo.sv]
`default_nettype none

// Two-entry queue, flop storage.
module mbp_fifo
    import mbp_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[hdl/mbp_front.sv]
`default_nettype none

// Classifies input words: drops no-ops, clamps the count and
// left-justifies the payload bits.
module mbp_front
    import mbp_pkg::*;
#(
    parameter int W     = 64,
    parameter int CNT_W = 7
)
(
    input  wire logic [1:0]       cmd,
    input  wire logic [W-1:0]     data_bits,
    input  wire logic [6:0]       bit_count,
    output logic                  keep,
    output op_t                   op,
    output logic [CNT_W-1:0]      cnt,
    output logic [W-1:0]          data_left
);

    logic [6:0]   n_cl;
    logic [6:0]   shamt;
    logic [W-1:0] d;
    logic         is_app;

    always_comb
    begin
        is_app = (cmd == CMD_DATA) || (cmd == CMD_ZERO);
        n_cl   = (bit_count > 7'(W)) ? 7'(W) : bit_count;
        d      = (cmd == CMD_ZERO) ? '0 : data_bits;
        // Shift by W when count is zero leaves nothing
        shamt     = 7'(W) - n_cl;
        data_left = d << shamt;
        cnt       = CNT_W'(n_cl);
        op        = (cmd == CMD_FLUSH) ? OP_FLUSH : OP_APPEND;
        keep      = (cmd == CMD_FLUSH) || (is_app && (n_cl != 7'd0));
    end

endmodule

`default_nettype wire

[hdl/mbp_back.sv]
`default_nettype none

// Holds pending bits at the top of a shift register and emits one byte
// per cycle while the result queue is not full.
module mbp_back
    import mbp_pkg::*;
#(
    parameter int W     = 64,
    parameter int CNT_W = 7
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire op_t              e_op,
    input  wire logic [CNT_W-1:0] e_cnt,
    input  wire logic [W-1:0]     e_data,
    output logic                  q_pop,
    input  wire logic             o_full,
    output logic                  o_push,
    output logic [RES_W-1:0]      o_word
);

    localparam int SH_W = W + BYTE_BITS;
    localparam int T_W  = $clog2(W + BYTE_BITS);
    localparam int BL_W = T_W - 3;

    logic [SH_W-1:0] sh_reg;
    logic [SH_W-1:0] sh_next;
    logic [2:0]      pcnt_reg;
    logic [2:0]      pcnt_next;
    logic [BL_W-1:0] left_reg;
    logic [BL_W-1:0] left_next;

    logic [SH_W-1:0] comb;
    logic [T_W-1:0]  t;
    logic [BL_W-1:0] nbytes;
    logic [7:0]      b;
    logic [3:0]      vb;
    logic            lst;

    always_comb
    begin
        // New bits land right below the pending ones at the top
        comb   = {sh_reg[SH_W-1 -: BYTE_BITS], {W{1'b0}}}
                 | ({e_data, {BYTE_BITS{1'b0}}} >> pcnt_reg);
        t      = T_W'(pcnt_reg) + T_W'(e_cnt);
        nbytes = BL_W'(t >> 3);

        sh_next   = sh_reg;
        pcnt_next = pcnt_reg;
        left_next = left_reg;
        q_pop     = 1'b0;
        o_push    = 1'b0;
        b         = sh_reg[SH_W-1 -: BYTE_BITS];
        vb        = FULL_BYTE_BITS;
        lst       = 1'b0;

        if (left_reg != '0)
        begin
            if (!o_full)
            begin
                o_push    = 1'b1;
                lst       = (left_reg == BL_W'(1));
                sh_next   = sh_reg << BYTE_BITS;
                left_next = left_reg - BL_W'(1);
            end
        end
        else if (!q_empty && !o_full)
        begin
            q_pop = 1'b1;
            unique case (e_op)
                OP_FLUSH:
                begin
                    if (pcnt_reg != 3'd0)
                    begin
                        o_push = 1'b1;
                        vb     = {1'b0, pcnt_reg};
                        lst    = 1'b1;
                    end
                    sh_next   = '0;
                    pcnt_next = 3'd0;
                end
                OP_APPEND:
                begin
                    pcnt_next = t[2:0];
                    if (nbytes != '0)
                    begin
                        o_push    = 1'b1;
                        b         = comb[SH_W-1 -: BYTE_BITS];
                        lst       = (nbytes == BL_W'(1));
                        sh_next   = comb << BYTE_BITS;
                        left_next = nbytes - BL_W'(1);
                    end
                    else
                    begin
                        sh_next = comb;
                    end
                end
                default:
                begin
                    sh_next = sh_reg;
                end
            endcase
        end
        o_word = {b, vb, lst};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_reg   <= '0;
            pcnt_reg <= 3'd0;
            left_reg <= '0;
        end
        else
        begin
            sh_reg   <= sh_next;
            pcnt_reg <= pcnt_next;
            left_reg <= left_next;
        end
    end

endmodule

`default_nettype wire
